// File: design/trial_division_prime_sieve_core_macros.svh
// Assertion macros used by the prime sieve core.
`ifndef TRIAL_DIVISION_PRIME_SIEVE_CORE_MACROS_SVH
`define TRIAL_DIVISION_PRIME_SIEVE_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TDPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TDPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tdps_pkg.sv
// Shared constants, types and helper functions of the prime sieve.
package tdps_pkg;

  // Table depth and arithmetic width.
  localparam int MAX_PRIMES = 64;
  localparam int VALUE_BITS = 16;

  // Width of the candidate and prime fields on the ports.
  localparam int FIELD_BITS = 16;

  // Table index, table count and bit-step counter widths.
  localparam int IDX_W  = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int CNT_W  = $clog2(MAX_PRIMES + 1);
  localparam int STEP_W = $clog2(VALUE_BITS + 1);

  // Entry zero of the table always holds the first prime.
  localparam logic [VALUE_BITS-1:0] FIRST_PRIME = VALUE_BITS'(2);

  // Status of the remainder unit as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_status_t;

  // Port field to internal value: keeps the low VALUE_BITS bits.
  function automatic logic [VALUE_BITS-1:0] to_value(input logic [FIELD_BITS-1:0] x);
    logic [VALUE_BITS-1:0] v;
    v = '0;
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (i < FIELD_BITS) begin
        v[i] = x[i];
      end
    end
    return v;
  endfunction

  // Internal value to port field: zero-extends or truncates.
  function automatic logic [FIELD_BITS-1:0] to_field(input logic [VALUE_BITS-1:0] v);
    logic [FIELD_BITS-1:0] x;
    x = '0;
    for (int i = 0; i < FIELD_BITS; i++) begin
      if (i < VALUE_BITS) begin
        x[i] = v[i];
      end
    end
    return x;
  endfunction

endpackage

// File: design/trial_division_prime_sieve_core.sv
// Trial-division prime sieve: the sequencer, prime table and result register.
//
// Each candidate request is divided in turn by every prime in the table, in
// table order, using a bit-serial remainder unit that consumes one dividend bit
// per cycle. Every stored prime tried takes a table read, a load of the
// remainder unit, VALUE_BITS shift steps and a check of the remainder, so the
// time for a candidate grows with the number of primes tried before one
// divides it or the table is exhausted; the default configuration has 64
// entries of 16 bits. A divisible candidate produces no result; a survivor
// is appended to the table and emitted, or emitted with table_overflow set
// once the table is full. The result register lets the next candidate be
// taken while a prime still waits on the output. No clearing pass is needed
// after reset: entry zero always reads as 2 and only entries below the prime
// count are ever read.
module trial_division_prime_sieve_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_candidate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_found_prime,
  output logic        out_table_overflow
);

  `include "trial_division_prime_sieve_core_macros.svh"

  localparam int VB = tdps_pkg::VALUE_BITS;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_START = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [VB-1:0]                  cand_r, cand_nxt;
  logic [tdps_pkg::CNT_W-1:0]     idx_r, idx_nxt;
  logic [tdps_pkg::CNT_W-1:0]     prime_count_r, prime_count_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [15:0]                    out_prime_r, out_prime_nxt;
  logic                           out_ovf_r, out_ovf_nxt;

  logic                           accept;
  logic                           load_out;
  logic                           table_full;
  logic [tdps_pkg::CNT_W-1:0]     idx_inc;
  logic [VB-1:0]                  ram_rdata;
  logic [VB-1:0]                  divisor;
  logic                           rem_start;
  tdps_pkg::rem_status_t          rem_st;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign table_full = (prime_count_r == tdps_pkg::CNT_W'(tdps_pkg::MAX_PRIMES));
  assign idx_inc    = idx_r + tdps_pkg::CNT_W'(1);
  assign load_out   = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign rem_start  = (state_r == ST_START);

  // Entry zero is the fixed prime 2; the RAM is never written there.
  assign divisor = (idx_r == '0) ? tdps_pkg::FIRST_PRIME : ram_rdata;

  // Prime table storage.
  tdps_ram #(
    .WIDTH (VB),
    .DEPTH (tdps_pkg::MAX_PRIMES)
  ) u_table (
    .clk     (clk),
    .wr_en   (load_out && !table_full),
    .wr_addr (prime_count_r[tdps_pkg::IDX_W-1:0]),
    .wr_data (cand_r),
    .rd_addr (idx_r[tdps_pkg::IDX_W-1:0]),
    .rd_data (ram_rdata)
  );

  // Shared remainder unit.
  tdps_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (cand_r),
    .divisor  (divisor),
    .status   (rem_st)
  );

  // Sequencer: walk the table, one stored prime per remainder pass.
  always_comb begin
    state_nxt       = state_r;
    cand_nxt        = cand_r;
    idx_nxt         = idx_r;
    prime_count_nxt = prime_count_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cand_nxt  = tdps_pkg::to_value(in_candidate);
          idx_nxt   = '0;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV: begin
        if (rem_st.done) begin
          if (rem_st.zero) begin
            state_nxt = ST_IDLE;
          end else if (idx_inc == prime_count_r) begin
            state_nxt = ST_EMIT;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          if (!table_full) begin
            prime_count_nxt = prime_count_r + tdps_pkg::CNT_W'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result register: holds one prime until it is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_prime_nxt = out_prime_r;
    out_ovf_nxt   = out_ovf_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_prime_nxt = tdps_pkg::to_field(cand_r);
      out_ovf_nxt   = table_full;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      prime_count_r <= tdps_pkg::CNT_W'(1);
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      prime_count_r <= prime_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    cand_r      <= cand_nxt;
    idx_r       <= idx_nxt;
    out_prime_r <= out_prime_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_found_prime    = out_prime_r;
  assign out_table_overflow = out_ovf_r;

  // Consistency checks on the sequencer, table count and result register.
  `TDPS_ASSERT_NOW(a_count_range, 1'b1, (prime_count_r != '0) && (prime_count_r <= tdps_pkg::CNT_W'(tdps_pkg::MAX_PRIMES)), "prime count out of range")
  `TDPS_ASSERT_NOW(a_done_in_div, rem_st.done, state_r == ST_DIV, "remainder finished outside a division pass")
  `TDPS_ASSERT_NOW(a_idle_unit_free, in_ready, !rem_st.busy, "request taken while remainder unit busy")
  `TDPS_ASSERT_NEXT(a_overflow_full, load_out && table_full, out_table_overflow && (prime_count_r == tdps_pkg::CNT_W'(tdps_pkg::MAX_PRIMES)), "overflow result without a full table")

endmodule

// File: design/tdps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tdps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/tdps_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module tdps_rem (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [tdps_pkg::VALUE_BITS-1:0] dividend,
  input  logic [tdps_pkg::VALUE_BITS-1:0] divisor,
  output tdps_pkg::rem_status_t           status
);

  localparam int VB = tdps_pkg::VALUE_BITS;

  logic [VB-1:0]                   shift_r, shift_nxt;
  logic [VB:0]                     rem_r, rem_nxt;
  logic [VB-1:0]                   div_r, div_nxt;
  logic [tdps_pkg::STEP_W-1:0]     steps_r, steps_nxt;
  logic                            run_r, run_nxt;
  logic                            done_r, done_nxt;
  logic [VB:0]                     trial;
  logic [VB:0]                     diff;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  assign trial = {rem_r[VB-1:0], shift_r[VB-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    steps_nxt = steps_r;
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    if (start) begin
      shift_nxt = dividend;
      rem_nxt   = '0;
      div_nxt   = divisor;
      steps_nxt = tdps_pkg::STEP_W'(VB);
      run_nxt   = 1'b1;
    end else if (run_r) begin
      shift_nxt = {shift_r[VB-2:0], 1'b0};
      rem_nxt   = (trial >= {1'b0, div_r}) ? diff : trial;
      steps_nxt = steps_r - tdps_pkg::STEP_W'(1);
      if (steps_r == tdps_pkg::STEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    steps_r <= steps_nxt;
  end

  assign status.busy = run_r;
  assign status.done = done_r;
  assign status.zero = (rem_r == '0);

endmodule

// File: sim/tb_trial_division_prime_sieve_core.sv
// Self-checking testbench for the trial-division prime sieve core.
`timescale 1ns / 100ps

module tb_trial_division_prime_sieve_core;

  // Longest run without any accepted request or result before giving up.
  localparam int IDLE_LIMIT   = 10000;
  // Worst-case time for one candidate to pass all 64 table entries, rounded up.
  localparam int DRAIN_CYCLES = 1300;
  localparam int ITEM_TARGET  = 540;

  typedef struct packed {
    logic [tdps_pkg::FIELD_BITS-1:0] found_prime;
    logic                            table_overflow;
  } prime_result_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [tdps_pkg::FIELD_BITS-1:0] in_candidate;
  logic                            out_valid;
  logic                            out_ready;
  logic [tdps_pkg::FIELD_BITS-1:0] out_found_prime;
  logic                            out_table_overflow;

  // Candidates waiting to be offered, and primes still owed by the block.
  logic [tdps_pkg::FIELD_BITS-1:0] pending_candidates[$];
  prime_result_t                   expected_primes[$];

  // Shadow copy of the block's prime table.
  logic [tdps_pkg::VALUE_BITS-1:0] known_primes[tdps_pkg::MAX_PRIMES];
  int                              known_count;

  int  mismatches;
  int  items_queued;
  int  idle_cycles;
  bit  req_taken;
  int  burst_left;
  int  gap_left;
  int  rx_mode;
  int  rx_window;
  int  rx_tick;

  trial_division_prime_sieve_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_candidate       (in_candidate),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found_prime    (out_found_prime),
    .out_table_overflow (out_table_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Divides the candidate by every stored prime; a survivor is appended to the
  // table, or flagged as overflow once the table is full.
  function automatic bit sieve_check(input logic [tdps_pkg::FIELD_BITS-1:0] cand,
                                     output prime_result_t res);
    logic [tdps_pkg::VALUE_BITS-1:0] v;
    bit                              divided;
    v       = tdps_pkg::VALUE_BITS'(cand);
    divided = 1'b0;
    res     = '0;
    for (int i = 0; i < known_count; i++) begin
      if (known_primes[i] != '0 && (v % known_primes[i]) == '0) begin
        divided = 1'b1;
      end
    end
    if (divided) begin
      return 1'b0;
    end
    res.found_prime    = tdps_pkg::FIELD_BITS'(v);
    res.table_overflow = (known_count >= tdps_pkg::MAX_PRIMES);
    if (known_count < tdps_pkg::MAX_PRIMES) begin
      known_primes[known_count] = v;
      known_count++;
    end
    return 1'b1;
  endfunction

  task automatic queue_request(input int unsigned value);
    pending_candidates.push_back(tdps_pkg::FIELD_BITS'(value));
    items_queued++;
  endtask

  // Waits until every request has gone in and every owed prime has come out.
  task automatic wait_drained();
    while (pending_candidates.size() != 0 || in_valid || expected_primes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Request driver: bursts of back-to-back requests separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (!(in_valid && !req_taken)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_candidates.size() != 0) begin
          in_candidate <= pending_candidates.pop_front();
          in_valid     <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
      req_taken = 1'b0;
    end
  end

  // Result sink: the stall pattern changes at the end of each randomly sized window.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_tick++;
      if (rx_tick >= rx_window) begin
        rx_tick   = 0;
        rx_window = $urandom_range(20, 120);
        rx_mode   = $urandom_range(0, 3);
      end
      case (rx_mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_ready <= rx_tick[3];
        end
      endcase
    end
  end

  // Monitor: predicts on each accepted request and checks each accepted result.
  always @(posedge clk) begin : monitor
    prime_result_t pred;
    prime_result_t want;
    bit            moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && in_ready) begin
        moved     = 1'b1;
        req_taken = 1'b1;
        if (sieve_check(in_candidate, pred)) begin
          expected_primes.push_back(pred);
        end
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (expected_primes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected result: prime %0d overflow %0b",
                     out_found_prime, out_table_overflow);
          end
        end else begin
          want = expected_primes.pop_front();
          if (out_found_prime !== want.found_prime ||
              out_table_overflow !== want.table_overflow) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: prime %0d overflow %0b, expected prime %0d overflow %0b",
                       out_found_prime, out_table_overflow,
                       want.found_prime, want.table_overflow);
            end
          end
        end
      end
      // Watchdog on a stalled handshake.
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    int unsigned cursor;
    int          pick;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_candidate = '0;
    out_ready    = 1'b0;
    mismatches   = 0;
    items_queued = 0;
    idle_cycles  = 0;
    req_taken    = 1'b0;
    burst_left   = 1;
    gap_left     = 0;
    rx_mode      = 0;
    rx_window    = 50;
    rx_tick      = 0;
    for (int i = 0; i < tdps_pkg::MAX_PRIMES; i++) begin
      known_primes[i] = '0;
    end
    known_primes[0] = tdps_pkg::VALUE_BITS'(2);
    known_count     = 1;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero, the seed prime again, small primes, repeats, extremes,
    // and composites whose factors are not yet in the table.
    queue_request(0);
    queue_request(2);
    queue_request(3);
    queue_request(4);
    queue_request(5);
    queue_request(3);
    queue_request(65535);
    queue_request(65534);
    queue_request(49);
    queue_request(9);
    queue_request(25);
    queue_request(7);
    queue_request(11);
    queue_request(13);
    queue_request(32768);
    queue_request(121);
    queue_request(21845);
    queue_request(43690);
    queue_request(289);
    wait_drained();

    // Well-formed ascending runs until the table fills, pausing after each run
    // until every prime owed has come out.
    cursor = 14;
    while (known_count < tdps_pkg::MAX_PRIMES) begin
      repeat (24) begin
        queue_request(cursor);
        cursor += ($urandom_range(0, 3) == 0) ? 2 : 1;
      end
      wait_drained();
    end

    // Table full: random values, further ascending values and repeats.
    while (items_queued < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        queue_request($urandom_range(0, 65535));
      end else if (pick <= 7) begin
        cursor += $urandom_range(1, 3);
        queue_request(cursor);
      end else if (pick == 8) begin
        queue_request(32'(known_primes[$urandom_range(0, known_count - 1)]));
      end else begin
        queue_request($urandom_range(2, 400));
      end
    end
    // One is divisible by nothing stored; with the table full it overflows.
    queue_request(1);
    queue_request(0);
    queue_request(65535);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_primes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/tdps_pkg.sv
design/tdps_ram.sv
design/tdps_rem.sv
design/trial_division_prime_sieve_core.sv
sim/tb_trial_division_prime_sieve_core.sv
